// ===== src/sflt_pkg.sv =====
// ============================================================================
// sflt_pkg: source failure lockout table package
// Shared types, sizes and codes for the failure lockout table.
// ============================================================================
package sflt_pkg;

    localparam int ENTRIES   = 16;
    localparam int COUNT_MAX = 255;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // The count is eight bits wide, so it saturates at the smaller bound.
    localparam logic [7:0] COUNT_CAP = 8'((COUNT_MAX < 255) ? COUNT_MAX : 255);

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STORAGE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] source_addr;
        logic [31:0] now_seconds;
    } sflt_in_t;

    typedef struct packed {
        logic       blocked;
        logic [7:0] failures;
        logic       table_full;
    } sflt_out_t;

    typedef struct packed {
        logic [31:0] check_window;
        logic [31:0] storage_window;
        logic [7:0]  attempt_limit;
    } sflt_cfg_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  count;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } sflt_entry_t;

    localparam int ENTRY_W = $bits(sflt_entry_t);

    // Verdict on one entry read back during the table walk.
    typedef struct packed {
        logic       aged;
        logic       free;
        logic       match;
        logic       block;
        logic [7:0] next_count;
    } sflt_eval_t;

endpackage

// ===== src/sflt_ram.sv =====
// ============================================================================
// sflt_ram: entry storage
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module sflt_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 104,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sflt_eval.sv =====
// ============================================================================
// sflt_eval: entry evaluation
// Judges one stored entry against the current transaction and the settings.
// ============================================================================
module sflt_eval (
    input  logic               valid,
    input  sflt_pkg::sflt_entry_t entry,
    input  sflt_pkg::sflt_in_t req,
    input  sflt_pkg::sflt_cfg_t cfg,
    output sflt_pkg::sflt_eval_t verdict
);

    import sflt_pkg::*;

    logic [31:0] span;

    // Modular difference, so time running backwards looks like a huge span.
    assign span = entry.last_time - entry.first_time;

    always_comb
    begin
        verdict.aged  = (req.mode == MODE_CHECK) && valid && (span > cfg.storage_window);
        verdict.free  = !valid;
        verdict.match = valid && !verdict.aged && (entry.addr == req.source_addr);
        verdict.block = (entry.count > cfg.attempt_limit) && (span <= cfg.check_window);
        verdict.next_count = (entry.count < COUNT_CAP) ? (entry.count + 8'd1) : entry.count;
    end

endmodule

// ===== src/source_failure_lockout_table_unit.sv =====
// ============================================================================
// source_failure_lockout_table_unit: failed attempt lockout table
// Counts failures per source address and reports sources that are locked out.
// ============================================================================
// Busy drops in the cycle that shows the result, so a new transaction is not
// taken until the previous result is shown. The walk reads one entry per cycle
// from the entry RAM, then judges the last entry in DRAIN and writes back a
// record in WRITE; the receiver cannot stall the result.
// Reset clears all entry valid bits and loads the default settings at once.
// ============================================================================
module source_failure_lockout_table_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sflt_pkg::sflt_in_t                  item,
    output logic                                done,
    output sflt_pkg::sflt_out_t                 result,
    input  logic                                cfg_we,
    input  logic [sflt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sflt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sflt_pkg::*;

    // IDLE waits for a transaction. SCAN issues one RAM read per entry in index
    // order; the entry read in one cycle is judged in the next. DRAIN judges the
    // last entry. WRITE registers the result; a record updates or inserts an entry.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    state_t      state_reg;
    sflt_cfg_t   cfg_reg;
    sflt_in_t    req_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic        eval_vld_reg;

    // Walk results: the first matching entry and the lowest free entry.
    logic        hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    sflt_entry_t hit_entry_reg;
    logic [7:0]  hit_count_reg;
    logic        hit_block_reg;
    logic        free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic        done_reg;
    sflt_out_t   result_reg;

    sflt_entry_t rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    sflt_eval_t  verdict;

    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    sflt_entry_t wr_entry;

    sflt_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign rd_entry = sflt_entry_t'(rd_data);

    sflt_eval u_eval (
        .valid   (valid_reg[eval_idx_reg]),
        .entry   (rd_entry),
        .req     (req_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    // The write-back happens only in the WRITE state of a record transaction.
    // A hit keeps address and first time and refreshes count and last time;
    // a miss with room fills the lowest free entry.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = free_idx_reg;
        wr_entry = '{addr: req_reg.source_addr, count: 8'd1,
                     first_time: req_reg.now_seconds, last_time: req_reg.now_seconds};
        if ((state_reg == ST_WRITE) && (req_reg.mode == MODE_RECORD))
        begin
            if (hit_reg)
            begin
                wr_en    = 1'b1;
                wr_addr  = hit_idx_reg;
                wr_entry = '{addr: hit_entry_reg.addr, count: hit_count_reg,
                             first_time: hit_entry_reg.first_time,
                             last_time: req_reg.now_seconds};
            end
            else if (free_reg)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= '{check_window: 32'd300, storage_window: 32'd86400,
                               attempt_limit: 8'd5};
            req_reg       <= '0;
            valid_reg     <= '0;
            idx_reg       <= '0;
            eval_idx_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            hit_entry_reg <= '0;
            hit_count_reg <= '0;
            hit_block_reg <= 1'b0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            // The result strobe is raised in the cycle after the write-back cycle.
            done_reg <= (state_reg == ST_WRITE);

            // The user must write settings only while the table is idle; not enforced here.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHECK_WINDOW:   cfg_reg.check_window   <= cfg_data;
                    REG_STORAGE_WINDOW: cfg_reg.storage_window <= cfg_data;
                    REG_ATTEMPT_LIMIT:  cfg_reg.attempt_limit  <= cfg_data[7:0];
                    default:            ;
                endcase
            end

            eval_vld_reg <= (state_reg == ST_SCAN);
            eval_idx_reg <= idx_reg;

            // Judge the entry whose read data arrived this cycle. Aging clears
            // the valid bit, so an aged entry can neither match nor block.
            if (eval_vld_reg)
            begin
                if (verdict.aged)
                begin
                    valid_reg[eval_idx_reg] <= 1'b0;
                end
                if (verdict.match && !hit_reg)
                begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= eval_idx_reg;
                    hit_entry_reg <= rd_entry;
                    hit_count_reg <= (req_reg.mode == MODE_RECORD) ?
                                     verdict.next_count : rd_entry.count;
                    hit_block_reg <= verdict.block;
                end
                if (verdict.free && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= eval_idx_reg;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= item;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_IDLE;
                    if (req_reg.mode == MODE_RECORD)
                    begin
                        result_reg.blocked <= 1'b0;
                        if (hit_reg)
                        begin
                            result_reg.failures   <= hit_count_reg;
                            result_reg.table_full <= 1'b0;
                        end
                        else if (free_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            result_reg.failures   <= 8'd1;
                            result_reg.table_full <= 1'b0;
                        end
                        else
                        begin
                            result_reg.failures   <= 8'd0;
                            result_reg.table_full <= 1'b1;
                        end
                    end
                    else
                    begin
                        result_reg.blocked    <= hit_reg && hit_block_reg;
                        result_reg.failures   <= hit_reg ? hit_count_reg : 8'd0;
                        result_reg.table_full <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows the write-back cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE))
        else $error("result strobe without a write-back cycle");

    // A rejected insert means every entry was in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (&valid_reg))
        else $error("table_full reported with a free entry");

    // Only a check transaction can report a blocked source.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.blocked) |-> (req_reg.mode == MODE_CHECK))
        else $error("blocked reported for a record transaction");

    // An accepted transaction makes the table busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the walk");

endmodule
